[src/assert_macros.svh]
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// checked outside reset
`define ASSERT_DIS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_DIS(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

[src/scr_pkg.sv]
`default_nettype none

package scr_pkg;

  localparam int HEADER_BYTES     = 12;
  localparam int HDR_CRC_BYTES    = 9;
  localparam int MAX_FRAME_BYTES  = 512;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam logic [7:0] SYNC_CHAR_RESET  = 8'd65;
  localparam logic [8:0] MAX_LENGTH_RESET = 9'd488;

  // configuration register indexes
  localparam logic REG_SYNC_CHAR  = 1'b0;
  localparam logic REG_MAX_LENGTH = 1'b1;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD     = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [8:0]  byte_index;
    logic [7:0]  destination;
    logic [7:0]  msg_type;
    logic [8:0]  frame_length;
    logic [31:0] mac_address;
  } res_t;

  // one byte of reflected crc-16
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (r[0]) begin
        r = (r >> 1) ^ CRC_POLY;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[src/scr_hdr_crc.sv]
`default_nettype none

// crc over the last nine bytes, from a ring of staggered accumulators;
// crc9 is the value that ended three bytes back
module scr_hdr_crc
  import scr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step,
  input  wire logic [7:0]  rx_byte,
  output logic      [15:0] crc9
);

  localparam int PW = $clog2(HDR_CRC_BYTES);

  logic [15:0]   acc [HDR_CRC_BYTES];
  logic [15:0]   hist [3];
  logic [PW-1:0] phase;
  logic [PW-1:0] phase_next;
  logic [15:0]   completed;

  assign phase_next = (phase == PW'(HDR_CRC_BYTES - 1)) ? '0 : phase + 1'b1;
  // the accumulator after the one restarting now has seen eight bytes
  assign completed  = crc_byte(acc[phase_next], rx_byte);
  assign crc9       = hist[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (step) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      for (int i = 0; i < HDR_CRC_BYTES; i++) begin
        if (phase == PW'(i)) begin
          acc[i] <= crc_byte(CRC_INIT, rx_byte);
        end else begin
          acc[i] <= crc_byte(acc[i], rx_byte);
        end
      end
      hist[0] <= completed;
      hist[1] <= hist[0];
      hist[2] <= hist[1];
    end
  end

endmodule

`default_nettype wire

[src/scr_out_reg.sv]
`default_nettype none

module scr_out_reg
  import scr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load,
  input  wire res_t        res,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [79:0] m_tdata,  // data_byte, byte_index, destination, msg_type,
                                     // frame_length, mac_address, zero fill
  output logic      [1:0]  m_tuser   // kind
);

  res_t held;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign m_tdata = {6'd0, held.mac_address, held.frame_length, held.msg_type,
                    held.destination, held.byte_index, held.data_byte};
  assign m_tuser = held.kind;

endmodule

`default_nettype wire

[src/sync_crc16_frame_receiver.sv]
// an accepted byte passes the input register, then the result register, before
// its result shows on m_tvalid
// throughput: one byte per cycle while no result waits on m_tready; the header crc comes
// from a ring of nine 16-bit crc accumulators, so no step chains more than one crc byte
// a result waits in the output register while the next byte is taken
// reset (rst, synchronous): hunting with an empty window, registers to defaults
`default_nettype none
`include "assert_macros.svh"

module sync_crc16_frame_receiver
  import scr_pkg::*;
#(
  parameter int MAX_FRAME_BYTES_P = MAX_FRAME_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // rx_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [79:0] m_tdata,   // data_byte, byte_index, destination, msg_type,
                                      // frame_length, mac_address, zero fill
  output logic      [1:0]  m_tuser,   // kind
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [8:0]  cfg_data
);

  localparam int FRAME_CAP = MAX_FRAME_BYTES_P - HEADER_BYTES;

  logic [7:0]  sync_char;
  logic [8:0]  max_length;

  logic        in_valid;
  logic [7:0]  in_byte;

  logic [7:0]  window [HEADER_BYTES];
  logic [7:0]  win_next [HEADER_BYTES];
  logic [3:0]  fill;
  logic        in_body;
  logic [8:0]  bytes_left;
  logic [15:0] running_crc;
  logic [7:0]  crc_low_hold;
  logic [8:0]  payload_count;
  logic [7:0]  hdr_dest;
  logic [7:0]  hdr_type;
  logic [8:0]  hdr_len;
  logic [31:0] hdr_mac;

  logic        produces;
  logic        advance;
  logic        verdict_taken;
  logic [15:0] hdr_crc;
  logic [15:0] len;
  logic        header_ok;
  logic        is_payload;
  logic [15:0] got_crc;
  res_t        res;

  assign produces = in_body && (bytes_left != 9'd2);
  assign advance  = in_valid && (!produces || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  assign verdict_taken = advance && in_body && (bytes_left == 9'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_char  <= SYNC_CHAR_RESET;
      max_length <= MAX_LENGTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SYNC_CHAR:  sync_char  <= cfg_data[7:0];
        REG_MAX_LENGTH: max_length <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  scr_hdr_crc u_hdr_crc (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx_byte (in_byte),
    .crc9    (hdr_crc)
  );

  // window as it stands once this byte is in, oldest byte first
  always_comb begin
    for (int i = 0; i < HEADER_BYTES - 1; i++) begin
      win_next[i] = window[i + 1];
    end
    win_next[HEADER_BYTES - 1] = in_byte;
  end

  assign len = {win_next[4], win_next[3]};

  assign header_ok = (win_next[0] == sync_char) && (in_byte == sync_char) &&
                     (hdr_crc == {win_next[10], win_next[9]}) &&
                     (len >= 16'd2) && (len <= {7'd0, max_length}) &&
                     (len <= 16'(FRAME_CAP));

  assign is_payload = bytes_left > 9'd2;
  assign got_crc    = {in_byte, crc_low_hold};

  always_comb begin
    res.destination  = hdr_dest;
    res.msg_type     = hdr_type;
    res.frame_length = hdr_len;
    res.mac_address  = hdr_mac;
    res.byte_index   = payload_count;
    if (is_payload) begin
      res.kind      = KIND_PAYLOAD;
      res.data_byte = in_byte;
    end else begin
      res.kind      = (got_crc == running_crc) ? KIND_GOOD : KIND_BAD;
      res.data_byte = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < HEADER_BYTES; i++) begin
        window[i] <= win_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill          <= 4'd0;
      in_body       <= 1'b0;
      bytes_left    <= 9'd0;
      running_crc   <= CRC_INIT;
      crc_low_hold  <= 8'd0;
      payload_count <= 9'd0;
      hdr_dest      <= 8'd0;
      hdr_type      <= 8'd0;
      hdr_len       <= 9'd0;
      hdr_mac       <= 32'd0;
    end else if (advance) begin
      if (!in_body) begin
        if (fill < 4'(HEADER_BYTES - 1)) begin
          fill <= fill + 4'd1;
        end else if (header_ok) begin
          // header crc bytes bring the crc to zero, only the closing sync remains
          running_crc   <= crc_byte(16'h0000, in_byte);
          hdr_dest      <= win_next[1];
          hdr_type      <= win_next[2];
          hdr_len       <= len[8:0];
          hdr_mac       <= {win_next[8], win_next[7], win_next[6], win_next[5]};
          bytes_left    <= len[8:0];
          payload_count <= 9'd0;
          in_body       <= 1'b1;
        end
      end else if (is_payload) begin
        running_crc   <= crc_byte(running_crc, in_byte);
        payload_count <= payload_count + 9'd1;
        bytes_left    <= bytes_left - 9'd1;
      end else if (bytes_left == 9'd2) begin
        crc_low_hold <= in_byte;
        bytes_left   <= 9'd1;
      end else begin
        in_body     <= 1'b0;
        bytes_left  <= 9'd0;
        fill        <= 4'd0;
        running_crc <= CRC_INIT;
      end
    end
  end

  scr_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && produces),
    .res      (res),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  `ASSERT_DIS(a_body_has_bytes, clk, rst, in_body |-> bytes_left != 9'd0, "body, no bytes left")
  `ASSERT_DIS(a_verdict_ends_frame, clk, rst, verdict_taken |=> !in_body, "frame open after verdict")
  `ASSERT_ALWAYS(a_reset_clears_out, clk, rst |=> !m_tvalid, "result valid after reset")

endmodule

`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import scr_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 6;
  localparam int FRAME_CAP      = MAX_FRAME_BYTES - HEADER_BYTES;

  typedef enum int {
    FAULT_NONE,
    FAULT_BODY_CRC,
    FAULT_SYNC_HEAD,
    FAULT_SYNC_TAIL,
    FAULT_HDR_CRC
  } frame_fault_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [79:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_we;
  logic        cfg_index;
  logic [8:0]  cfg_data;

  sync_crc16_frame_receiver uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // receiver copy: registers and frame state
  logic [7:0]  cfg_sync;
  int          cfg_max_len;
  logic [7:0]  win [HEADER_BYTES];
  int          win_fill;
  bit          in_frame;
  int          bytes_left;
  logic [15:0] frame_crc;
  logic [7:0]  crc_lo;
  logic [8:0]  pay_count;
  logic [7:0]  lat_dest;
  logic [7:0]  lat_type;
  logic [8:0]  lat_len;
  logic [31:0] lat_mac;

  logic [7:0]  rx_stream [$];
  res_t        reports_due [$];

  int send_idle_pct;
  int recv_idle_pct;
  int bytes_queued;
  int bytes_taken;
  int payload_seen;
  int frames_good;
  int frames_bad;
  int err_count;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = {acc[15:8], acc[7:0] ^ b};
    repeat (8) begin
      if (r[0]) begin
        r = {1'b0, r[15:1]} ^ CRC_POLY;
      end else begin
        r = {1'b0, r[15:1]};
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_count < 40) begin
      $display("mismatch %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $realtime);
    end
    err_count++;
  endtask

  // advance the receiver copy by one byte, queueing any report it causes
  task automatic track_rx_byte(input logic [7:0] b);
    res_t        r;
    logic [15:0] c;
    logic [15:0] hlen;
    r.kind         = KIND_PAYLOAD;
    r.data_byte    = 8'h00;
    r.byte_index   = pay_count;
    r.destination  = lat_dest;
    r.msg_type     = lat_type;
    r.frame_length = lat_len;
    r.mac_address  = lat_mac;
    if (!in_frame) begin
      if (win_fill >= HEADER_BYTES) win_fill = HEADER_BYTES - 1;
      win[win_fill] = b;
      win_fill++;
      if (win_fill == HEADER_BYTES) begin
        c = CRC_INIT;
        for (int i = 0; i < HDR_CRC_BYTES; i++) c = crc16_step(c, win[i]);
        hlen = {win[4], win[3]};
        if (win[0] == cfg_sync && win[HEADER_BYTES-1] == cfg_sync && c == {win[10], win[9]} &&
            hlen >= 2 && hlen <= cfg_max_len && hlen <= FRAME_CAP) begin
          for (int i = HDR_CRC_BYTES; i < HEADER_BYTES; i++) c = crc16_step(c, win[i]);
          frame_crc  = c;
          lat_dest   = win[1];
          lat_type   = win[2];
          lat_len    = hlen[8:0];
          lat_mac    = {win[8], win[7], win[6], win[5]};
          bytes_left = int'(hlen);
          pay_count  = '0;
          in_frame   = 1'b1;
        end else begin
          // slide the window by one byte
          for (int i = 0; i < HEADER_BYTES - 1; i++) win[i] = win[i+1];
          win[HEADER_BYTES-1] = 8'h00;
          win_fill = HEADER_BYTES - 1;
        end
      end
    end else if (bytes_left > 2) begin
      frame_crc   = crc16_step(frame_crc, b);
      r.data_byte = b;
      pay_count++;
      bytes_left--;
      reports_due.push_back(r);
    end else if (bytes_left == 2) begin
      crc_lo     = b;
      bytes_left = 1;
    end else begin
      r.kind = ({b, crc_lo} == frame_crc) ? KIND_GOOD : KIND_BAD;
      reports_due.push_back(r);
      in_frame   = 1'b0;
      bytes_left = 0;
      win_fill   = 0;
      frame_crc  = CRC_INIT;
    end
  endtask

  task automatic push_byte(input logic [7:0] b);
    rx_stream.push_back(b);
    bytes_queued++;
  endtask

  task automatic add_noise(input int n);
    for (int i = 0; i < n; i++) begin
      push_byte(($urandom_range(0, 3) == 0) ? cfg_sync : 8'($urandom_range(0, 255)));
    end
  endtask

  // header plus, where the header is one the receiver takes, payload and crc
  task automatic add_frame(input logic [7:0] dest, input logic [7:0] mtype,
                           input logic [15:0] len, input logic [31:0] mac,
                           input frame_fault_t fault);
    logic [7:0]  hb [HEADER_BYTES];
    logic [15:0] c;
    logic [7:0]  pb;
    hb[0] = cfg_sync;
    hb[1] = dest;
    hb[2] = mtype;
    hb[3] = len[7:0];
    hb[4] = len[15:8];
    hb[5] = mac[7:0];
    hb[6] = mac[15:8];
    hb[7] = mac[23:16];
    hb[8] = mac[31:24];
    c = CRC_INIT;
    for (int i = 0; i < HDR_CRC_BYTES; i++) c = crc16_step(c, hb[i]);
    hb[9]  = c[7:0];
    hb[10] = c[15:8];
    hb[11] = cfg_sync;
    case (fault)
      FAULT_SYNC_HEAD: hb[0] ^= 8'(1 << $urandom_range(0, 7));
      FAULT_SYNC_TAIL: hb[11] ^= 8'(1 << $urandom_range(0, 7));
      FAULT_HDR_CRC:   hb[9 + $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
      default: ;
    endcase
    for (int i = 0; i < HEADER_BYTES; i++) begin
      push_byte(hb[i]);
      if (i >= HDR_CRC_BYTES) c = crc16_step(c, hb[i]);
    end
    if ((fault == FAULT_NONE || fault == FAULT_BODY_CRC) && len >= 2 &&
        len <= cfg_max_len && len <= FRAME_CAP) begin
      for (int i = 0; i < len - 2; i++) begin
        pb = 8'($urandom_range(0, 255));
        push_byte(pb);
        c = crc16_step(c, pb);
      end
      if (fault == FAULT_BODY_CRC) c ^= 16'(1 << $urandom_range(0, 15));
      push_byte(c[7:0]);
      push_byte(c[15:8]);
    end
  endtask

  task automatic add_random_traffic(input int nbytes);
    int          start;
    int          pick;
    int          maxp;
    logic [15:0] len;
    start = bytes_queued;
    while (bytes_queued - start < nbytes) begin
      pick = $urandom_range(0, 99);
      maxp = (cfg_max_len > FRAME_CAP) ? FRAME_CAP : cfg_max_len;
      if (maxp < 2) begin
        len = 16'd2;
      end else if ($urandom_range(0, 19) == 0) begin
        len = 16'($urandom_range(2, maxp));
      end else begin
        len = 16'($urandom_range(2, (maxp < 20) ? maxp : 20));
      end
      if (pick < 65) begin
        add_frame(8'($urandom), 8'($urandom), len, $urandom, FAULT_NONE);
      end else if (pick < 77) begin
        add_frame(8'($urandom), 8'($urandom), len, $urandom, FAULT_BODY_CRC);
      end else if (pick < 83) begin
        add_frame(8'($urandom), 8'($urandom), len, $urandom, FAULT_SYNC_HEAD);
      end else if (pick < 87) begin
        add_frame(8'($urandom), 8'($urandom), len, $urandom, FAULT_SYNC_TAIL);
      end else if (pick < 91) begin
        add_frame(8'($urandom), 8'($urandom), len, $urandom, FAULT_HDR_CRC);
      end else if (pick < 94) begin
        // length field out of bounds
        case ($urandom_range(0, 3))
          0: len = 16'd0;
          1: len = 16'd1;
          2: len = 16'(maxp + 1);
          default: len = 16'($urandom_range(FRAME_CAP + 1, 16'hFFFF));
        endcase
        add_frame(8'($urandom), 8'($urandom), len, $urandom, FAULT_NONE);
      end else begin
        add_noise($urandom_range(1, 12));
      end
    end
  endtask

  // sender holds off until every report is in and the block has settled
  task automatic wait_drained();
    while (rx_stream.size() != 0 || s_tvalid || reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_settings(input logic [7:0] sync, input logic [8:0] max_len);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SYNC_CHAR;
    cfg_data  <= {1'b0, sync};
    @(posedge clk);
    cfg_index <= REG_MAX_LENGTH;
    cfg_data  <= max_len;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_sync    = sync;
    cfg_max_len = int'(max_len);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        track_rx_byte(s_tdata);
        bytes_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (rx_stream.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= rx_stream.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (m_tvalid && m_tready) begin
        if (reports_due.size() == 0) begin
          report_mismatch("report with nothing expected", m_tuser, 0);
        end else begin
          want = reports_due.pop_front();
          if (m_tuser != want.kind) report_mismatch("kind", m_tuser, want.kind);
          if (m_tdata[7:0] != want.data_byte)
            report_mismatch("data_byte", m_tdata[7:0], want.data_byte);
          if (m_tdata[16:8] != want.byte_index)
            report_mismatch("byte_index", m_tdata[16:8], want.byte_index);
          if (m_tdata[24:17] != want.destination)
            report_mismatch("destination", m_tdata[24:17], want.destination);
          if (m_tdata[32:25] != want.msg_type)
            report_mismatch("msg_type", m_tdata[32:25], want.msg_type);
          if (m_tdata[41:33] != want.frame_length)
            report_mismatch("frame_length", m_tdata[41:33], want.frame_length);
          if (m_tdata[73:42] != want.mac_address)
            report_mismatch("mac_address", m_tdata[73:42], want.mac_address);
          case (want.kind)
            KIND_PAYLOAD: payload_seen++;
            KIND_GOOD:    frames_good++;
            default:      frames_bad++;
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= 8'h00;
    m_tready  <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_SYNC_CHAR;
    cfg_data  <= 9'h000;
    cfg_sync    = SYNC_CHAR_RESET;
    cfg_max_len = int'(MAX_LENGTH_RESET);
    for (int i = 0; i < HEADER_BYTES; i++) win[i] = 8'h00;
    win_fill   = 0;
    in_frame   = 1'b0;
    bytes_left = 0;
    frame_crc  = CRC_INIT;
    crc_lo     = 8'h00;
    pay_count  = '0;
    lat_dest   = 8'h00;
    lat_type   = 8'h00;
    lat_len    = '0;
    lat_mac    = '0;
    bytes_queued  = 0;
    bytes_taken   = 0;
    payload_seen  = 0;
    frames_good   = 0;
    frames_bad    = 0;
    err_count     = 0;
    quiet_cycles  = 0;
    send_idle_pct = 32;
    recv_idle_pct = 80;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset settings: edge cases of header and body
    add_frame(8'h00, 8'h00, 16'd2, 32'h0000_0000, FAULT_NONE);
    add_frame(8'hFF, 8'hFF, 16'd3, 32'hFFFF_FFFF, FAULT_NONE);
    add_frame(8'hA5, 8'h5A, 16'd6, 32'h1234_5678, FAULT_BODY_CRC);
    add_noise(3);
    add_frame(8'h3C, 8'hC3, 16'd4, 32'h8000_0001, FAULT_NONE);
    add_frame(8'h11, 8'h22, 16'd4, 32'hDEAD_BEEF, FAULT_SYNC_HEAD);
    add_frame(8'h33, 8'h44, 16'd4, 32'h0F0F_0F0F, FAULT_SYNC_TAIL);
    add_frame(8'h55, 8'h66, 16'd4, 32'hF0F0_F0F0, FAULT_HDR_CRC);
    add_frame(8'h01, 8'h02, 16'd0, 32'h0000_0003, FAULT_NONE);
    add_frame(8'h01, 8'h02, 16'd1, 32'h0000_0003, FAULT_NONE);
    add_frame(8'h01, 8'h02, 16'd489, 32'h0000_0003, FAULT_NONE);
    add_frame(8'h01, 8'h02, 16'hFFFF, 32'h0000_0003, FAULT_NONE);
    add_frame(8'h01, 8'h02, 16'h0202, 32'h0000_0003, FAULT_NONE);
    add_frame(8'h77, 8'h88, 16'd5, 32'hAAAA_5555, FAULT_NONE);
    add_random_traffic(90);
    wait_drained();

    // smallest length limit that admits a frame, sync of zero
    write_settings(8'h00, 9'd2);
    add_frame(8'h10, 8'h20, 16'd3, 32'h0102_0304, FAULT_NONE);
    add_random_traffic(60);
    wait_drained();

    // length limit at the frame cap, sync of all ones
    send_idle_pct = 80;
    recv_idle_pct = 32;
    write_settings(8'hFF, 9'd500);
    add_frame(8'hC0, 8'h0C, 16'd500, 32'h5555_AAAA, FAULT_NONE);
    add_frame(8'hC0, 8'h0C, 16'd501, 32'h5555_AAAA, FAULT_NONE);
    add_random_traffic(70);
    wait_drained();

    // a limit below two rejects every header
    write_settings(8'h5A, 9'd1);
    add_frame(8'h01, 8'h01, 16'd2, 32'h0000_0000, FAULT_NONE);
    add_frame(8'h01, 8'h01, 16'd1, 32'h0000_0000, FAULT_NONE);
    add_noise(30);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_settings(8'($urandom_range(0, 255)), 9'($urandom_range(2, 500)));
    add_random_traffic(90);
    wait_drained();

    write_settings(SYNC_CHAR_RESET, MAX_LENGTH_RESET);
    add_random_traffic(90);
    wait_drained();

    if (reports_due.size() != 0) report_mismatch("reports never delivered", reports_due.size(), 0);
    $display("run took %0d bytes through six register settings, extremes included",
             bytes_taken);
    $display("checked %0d payload bytes and %0d frame verdicts (%0d good, %0d bad)",
             payload_seen, frames_good + frames_bad, frames_good, frames_bad);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
